/* rtl/retransmit_timer_queue_defines.svh */
// Assertion macros for the retransmit timer queue checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef RETRANSMIT_TIMER_QUEUE_DEFINES_SVH
`define RETRANSMIT_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define RTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rtq_pkg.sv */
// Shared types and codes for the retransmit timer queue.
// No dependencies; used by the controller, datapath, top level and checker.
`default_nettype none

package rtq_pkg;

  // Default sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int BYTE_WIDTH_DEF  = 32;
  localparam int TIME_WIDTH_DEF  = 32;

  // Operation codes of an input word
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACK    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd4;

  // Result status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Datapath actions issued by the controller
  localparam int ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ACK    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_EXP    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_IGNORE = 3'd6;

  typedef struct packed {
    logic             latch;  // capture the input word
    logic [ACT_W-1:0] act;
  } rtq_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;      // captured operation
    logic              empty;     // queue holds no entry
    logic              ack_last;  // acknowledge scan is at the last entry
    logic              exp_more;  // front entry is present and due
  } rtq_stat_t;

endpackage

`default_nettype wire

/* rtl/rtq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module rtq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/rtq_ctrl.sv */
// Controller state machine of the retransmit timer queue.
// Depends on rtq_pkg; drives the datapath through rtq_cmd_t.
`default_nettype none

module rtq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire rtq_pkg::rtq_stat_t stat_i,
  output rtq_pkg::rtq_cmd_t      cmd_o
);

  import rtq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ACK  = 2'd2;
  localparam logic [1:0] S_EXP  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.latch = 1'b0;
    cmd_o.act   = ACT_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        // front entry read is available here
        state_d = S_IDLE;
        case (stat_i.kind)
          KIND_ADD:    cmd_o.act = ACT_ADD;
          KIND_ACK: begin
            if (stat_i.empty) begin
              cmd_o.act = ACT_IGNORE;
            end else begin
              state_d = S_ACK;
            end
          end
          KIND_EXPIRE: state_d   = S_EXP;
          KIND_PEEK:   cmd_o.act = ACT_PEEK;
          KIND_POP:    cmd_o.act = ACT_POP;
          default:     cmd_o.act = ACT_IGNORE;
        endcase
      end
      S_ACK: begin
        cmd_o.act = ACT_ACK;
        if (stat_i.ack_last) begin
          state_d = S_IDLE;
        end
      end
      S_EXP: begin
        cmd_o.act = ACT_EXP;
        if (!stat_i.exp_more) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* rtl/rtq_datapath.sv */
// Datapath of the retransmit timer queue: circular entry store, pointers,
// scan counters and the result register. Depends on rtq_pkg and rtq_ram.
`default_nettype none

module rtq_datapath #(
  parameter int QUEUE_DEPTH = rtq_pkg::QUEUE_DEPTH_DEF,
  parameter int BYTE_WIDTH  = rtq_pkg::BYTE_WIDTH_DEF,
  parameter int TIME_WIDTH  = rtq_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire rtq_pkg::rtq_cmd_t                     cmd_i,
  output rtq_pkg::rtq_stat_t                         stat_o,
  input  wire logic [rtq_pkg::KIND_W-1:0]            kind_i,
  input  wire logic [BYTE_WIDTH-1:0]                 byte_position_i,
  input  wire logic [TIME_WIDTH-1:0]                 delay_i,
  input  wire logic [TIME_WIDTH-1:0]                 current_time_i,
  output logic                                       result_stb_o,
  output logic                                       entry_valid_o,
  output logic      [BYTE_WIDTH-1:0]                 entry_byte_o,
  output logic      [TIME_WIDTH-1:0]                 entry_due_o,
  output logic      [rtq_pkg::STATUS_W-1:0]          status_o,
  output logic      [$clog2(QUEUE_DEPTH+1)-1:0]      removed_count_o,
  output logic      [$clog2(QUEUE_DEPTH+1)-1:0]      occupancy_o,
  output logic                                       last_o
);

  import rtq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = BYTE_WIDTH + TIME_WIDTH;
  localparam logic [PTR_W:0]   DEPTH_P  = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // slot index modulo depth; argument is always below twice the depth
  function automatic logic [PTR_W-1:0] wrap_idx(input logic [PTR_W:0] s);
    logic [PTR_W:0] t;
    t = (s >= DEPTH_P) ? (s - DEPTH_P) : s;
    return t[PTR_W-1:0];
  endfunction

  // captured input word
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [BYTE_WIDTH-1:0] pos_q, pos_d;
  logic [TIME_WIDTH-1:0] delay_q, delay_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;

  // queue state
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;

  // acknowledge scan
  logic [PTR_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] keep_q, keep_d;

  // expire: popped entry held until the next front is judged
  logic                  pend_q, pend_d;
  logic [BYTE_WIDTH-1:0] pend_byte_q, pend_byte_d;
  logic [TIME_WIDTH-1:0] pend_due_q, pend_due_d;

  // result register
  logic                  stb_q, stb_d;
  logic                  ev_q, ev_d;
  logic [BYTE_WIDTH-1:0] eb_q, eb_d;
  logic [TIME_WIDTH-1:0] ed_q, ed_d;
  logic [STATUS_W-1:0]   st_q, st_d;
  logic [CNT_W-1:0]      rm_q, rm_d;
  logic [CNT_W-1:0]      occ_q, occ_d;
  logic                  last_q, last_d;

  // RAM port
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic [BYTE_WIDTH-1:0] r_byte;
  logic [TIME_WIDTH-1:0] r_due;
  logic [TIME_WIDTH:0]   due_sum;
  logic [TIME_WIDTH-1:0] due_sat;
  logic [PTR_W-1:0]      tail_idx, head_inc, ack_waddr, ack_raddr;
  logic [CNT_W-1:0]      idx_inc, keep_n;
  logic                  kept, empty, full, due_ok, ack_last;

  rtq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign r_byte = ram_rdata[ENT_W-1:TIME_WIDTH];
  assign r_due  = ram_rdata[TIME_WIDTH-1:0];

  assign due_sum = {1'b0, now_q} + {1'b0, delay_q};
  assign due_sat = due_sum[TIME_WIDTH] ? '1 : due_sum[TIME_WIDTH-1:0];

  assign tail_idx  = wrap_idx({1'b0, head_q} + (PTR_W + 1)'(count_q));
  assign head_inc  = wrap_idx({1'b0, head_q} + (PTR_W + 1)'(1));
  assign idx_inc   = CNT_W'(idx_q) + CNT_W'(1);
  assign ack_raddr = wrap_idx({1'b0, head_q} + (PTR_W + 1)'(idx_inc));
  assign ack_waddr = wrap_idx({1'b0, head_q} + (PTR_W + 1)'(keep_q));

  assign kept     = (r_byte > pos_q);
  assign keep_n   = keep_q + CNT_W'(kept);
  assign empty    = (count_q == '0);
  assign full     = (count_q == FULL_CNT);
  assign due_ok   = !empty && (r_due <= now_q);
  assign ack_last = (idx_inc == count_q);

  assign stat_o.kind     = kind_q;
  assign stat_o.empty    = empty;
  assign stat_o.ack_last = ack_last;
  assign stat_o.exp_more = due_ok;

  always_comb begin
    kind_d      = kind_q;
    pos_d       = pos_q;
    delay_d     = delay_q;
    now_d       = now_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    keep_d      = keep_q;
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    pend_due_d  = pend_due_q;
    stb_d       = 1'b0;
    ev_d        = ev_q;
    eb_d        = eb_q;
    ed_d        = ed_q;
    st_d        = st_q;
    rm_d        = rm_q;
    occ_d       = occ_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_waddr   = tail_idx;
    ram_wdata   = {pos_q, due_sat};
    ram_raddr   = head_q;  // keep the front entry on the read port

    if (cmd_i.latch) begin
      kind_d  = kind_i;
      pos_d   = byte_position_i;
      delay_d = delay_i;
      now_d   = current_time_i;
      idx_d   = '0;
      keep_d  = '0;
      pend_d  = 1'b0;
    end

    case (cmd_i.act)
      ACT_ADD: begin
        stb_d  = 1'b1;
        rm_d   = '0;
        last_d = 1'b1;
        if (full) begin
          ev_d  = 1'b0;
          eb_d  = '0;
          ed_d  = '0;
          st_d  = ST_FULL;
          occ_d = count_q;
        end else begin
          ram_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
          ev_d    = 1'b1;
          eb_d    = pos_q;
          ed_d    = due_sat;
          st_d    = ST_OK;
          occ_d   = count_q + CNT_W'(1);
        end
      end
      ACT_ACK: begin
        // compact survivors toward the head, one slot per cycle
        ram_we    = kept;
        ram_waddr = ack_waddr;
        ram_wdata = ram_rdata;
        ram_raddr = ack_raddr;
        keep_d    = keep_n;
        idx_d     = idx_q + PTR_W'(1);
        if (ack_last) begin
          count_d = keep_n;
          stb_d   = 1'b1;
          ev_d    = 1'b0;
          eb_d    = '0;
          ed_d    = '0;
          st_d    = ST_OK;
          rm_d    = count_q - keep_n;
          occ_d   = keep_n;
          last_d  = 1'b1;
        end
      end
      ACT_EXP: begin
        if (pend_q) begin
          stb_d  = 1'b1;
          ev_d   = 1'b1;
          eb_d   = pend_byte_q;
          ed_d   = pend_due_q;
          st_d   = ST_OK;
          rm_d   = '0;
          occ_d  = count_q;
          last_d = !due_ok;
        end
        if (due_ok) begin
          pend_d      = 1'b1;
          pend_byte_d = r_byte;
          pend_due_d  = r_due;
          head_d      = head_inc;
          count_d     = count_q - CNT_W'(1);
          ram_raddr   = head_inc;
        end else if (!pend_q) begin
          stb_d  = 1'b1;
          ev_d   = 1'b0;
          eb_d   = '0;
          ed_d   = '0;
          st_d   = empty ? ST_EMPTY : ST_OK;
          rm_d   = '0;
          occ_d  = count_q;
          last_d = 1'b1;
        end
      end
      ACT_PEEK, ACT_POP: begin
        stb_d  = 1'b1;
        last_d = 1'b1;
        if (empty) begin
          ev_d  = 1'b0;
          eb_d  = '0;
          ed_d  = '0;
          st_d  = ST_EMPTY;
          rm_d  = '0;
          occ_d = count_q;
        end else begin
          ev_d  = 1'b1;
          eb_d  = r_byte;
          ed_d  = r_due;
          st_d  = ST_OK;
          rm_d  = '0;
          occ_d = count_q;
          if (cmd_i.act == ACT_POP) begin
            head_d  = head_inc;
            count_d = count_q - CNT_W'(1);
            rm_d    = CNT_W'(1);
            occ_d   = count_q - CNT_W'(1);
          end
        end
      end
      ACT_IGNORE: begin
        stb_d  = 1'b1;
        ev_d   = 1'b0;
        eb_d   = '0;
        ed_d   = '0;
        st_d   = ST_OK;
        rm_d   = '0;
        occ_d  = count_q;
        last_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      keep_q  <= '0;
      pend_q  <= 1'b0;
      stb_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      keep_q  <= keep_d;
      pend_q  <= pend_d;
      stb_q   <= stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    pos_q       <= pos_d;
    delay_q     <= delay_d;
    now_q       <= now_d;
    pend_byte_q <= pend_byte_d;
    pend_due_q  <= pend_due_d;
    ev_q        <= ev_d;
    eb_q        <= eb_d;
    ed_q        <= ed_d;
    st_q        <= st_d;
    rm_q        <= rm_d;
    occ_q       <= occ_d;
    last_q      <= last_d;
  end

  assign result_stb_o    = stb_q;
  assign entry_valid_o   = ev_q;
  assign entry_byte_o    = eb_q;
  assign entry_due_o     = ed_q;
  assign status_o        = st_q;
  assign removed_count_o = rm_q;
  assign occupancy_o     = occ_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

/* rtl/retransmit_timer_queue.sv */
// Top level of the retransmit timer queue: controller plus datapath.
// Depends on rtq_pkg, rtq_ctrl, rtq_datapath (and rtq_ram below it).
`default_nettype none

// Retransmit timer queue. Holds up to QUEUE_DEPTH pending (byte, due time)
// entries in arrival order and runs one operation per input word: add,
// acknowledge, expire, peek front, pop front. A word is taken on a rising
// edge with start_i high and busy_o low. Results come out on the result
// ports for exactly one cycle each, flagged by result_stb_o, and cannot be
// held off; last_o marks the final result of a word. busy_o stays high
// while a word executes: through the acknowledge scan over every stored
// entry, and through the expire walk that pops each due front entry and
// then judges the next front; the next word can be taken the cycle busy_o
// drops. How long a word takes is set by the entry RAM, which has one read
// and one write port and is walked one entry per cycle. Each result is
// registered and appears in the cycle after the cycle that produced it. No
// clearing pass after reset: only slots below the fill count are ever used.

module retransmit_timer_queue #(
  parameter int QUEUE_DEPTH = rtq_pkg::QUEUE_DEPTH_DEF,
  parameter int BYTE_WIDTH  = rtq_pkg::BYTE_WIDTH_DEF,
  parameter int TIME_WIDTH  = rtq_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input word
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [rtq_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [BYTE_WIDTH-1:0]            byte_position_i,
  input  wire logic [TIME_WIDTH-1:0]            delay_i,
  input  wire logic [TIME_WIDTH-1:0]            current_time_i,
  // result word
  output logic                                  result_stb_o,
  output logic                                  entry_valid_o,
  output logic      [BYTE_WIDTH-1:0]            entry_byte_o,
  output logic      [TIME_WIDTH-1:0]            entry_due_o,
  output logic      [rtq_pkg::STATUS_W-1:0]     status_o,
  output logic      [$clog2(QUEUE_DEPTH+1)-1:0] removed_count_o,
  output logic      [$clog2(QUEUE_DEPTH+1)-1:0] occupancy_o,
  output logic                                  last_o
);

  import rtq_pkg::*;

  rtq_cmd_t  cmd;   // controller -> datapath
  rtq_stat_t stat;  // datapath -> controller

  // Sequencer: idle, execute, acknowledge scan, expire walk
  rtq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // Entry store is a circular buffer (head pointer + fill count). The
  // acknowledge scan reads slot head+i while writing survivors to
  // head+keep, which never passes the read point, so compaction is in place.
  rtq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .BYTE_WIDTH  (BYTE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (kind_i),
    .byte_position_i (byte_position_i),
    .delay_i         (delay_i),
    .current_time_i  (current_time_i),
    .result_stb_o    (result_stb_o),
    .entry_valid_o   (entry_valid_o),
    .entry_byte_o    (entry_byte_o),
    .entry_due_o     (entry_due_o),
    .status_o        (status_o),
    .removed_count_o (removed_count_o),
    .occupancy_o     (occupancy_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

/* rtl/rtq_sva.sv */
// Port-level checker for the retransmit timer queue, bound to the top level.
// Depends on rtq_pkg and retransmit_timer_queue_defines.svh.
`default_nettype none

`include "retransmit_timer_queue_defines.svh"

module rtq_sva #(
  parameter int QUEUE_DEPTH = rtq_pkg::QUEUE_DEPTH_DEF,
  parameter int BYTE_WIDTH  = rtq_pkg::BYTE_WIDTH_DEF,
  parameter int TIME_WIDTH  = rtq_pkg::TIME_WIDTH_DEF
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             start_i,
  input wire logic                             busy_i,
  input wire logic                             result_stb_i,
  input wire logic                             entry_valid_i,
  input wire logic [BYTE_WIDTH-1:0]            entry_byte_i,
  input wire logic [TIME_WIDTH-1:0]            entry_due_i,
  input wire logic [rtq_pkg::STATUS_W-1:0]     status_i,
  input wire logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy_i,
  input wire logic                             last_i
);

  import rtq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  `RTQ_ASSERT_NEXT(a_accept_busy, start_i && !busy_i, busy_i, "no busy after accepted word")

  `RTQ_ASSERT_NEXT(a_last_gap, result_stb_i && last_i, !result_stb_i, "result right after last")

  `RTQ_ASSERT_NOW(a_empty_payload, result_stb_i && !entry_valid_i, (entry_byte_i == '0) && (entry_due_i == '0), "payload set on result without entry")

  `RTQ_ASSERT_NOW(a_full_drop, result_stb_i && (status_i == ST_FULL), !entry_valid_i && (occupancy_i == CNT_W'(QUEUE_DEPTH)), "full status while queue not full")

endmodule

bind retransmit_timer_queue rtq_sva #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .BYTE_WIDTH  (BYTE_WIDTH),
  .TIME_WIDTH  (TIME_WIDTH)
) u_rtq_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_i        (busy_o),
  .result_stb_i  (result_stb_o),
  .entry_valid_i (entry_valid_o),
  .entry_byte_i  (entry_byte_o),
  .entry_due_i   (entry_due_o),
  .status_i      (status_o),
  .occupancy_i   (occupancy_o),
  .last_i        (last_o)
);

`default_nettype wire

/* tb/sv/retransmit_timer_queue_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for retransmit_timer_queue: directed and random command words.
// A built-in queue predictor checks every result; depends on rtq_pkg and the RTL.

module retransmit_timer_queue_test;
  import rtq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int BW    = BYTE_WIDTH_DEF;
  localparam int TW    = TIME_WIDTH_DEF;
  localparam int CW    = $clog2(DEPTH + 1);
  // Cycles with no word taken and no result seen before we give up.
  // Slowest legal step is a sender gap plus an expire that pops a full queue.
  localparam int STALL_LIMIT = 2000;
  // Settle time after the last expected result.
  localparam int DRAIN_CYCLES = 40;

  // One result word as the block should present it.
  typedef struct {
    logic                valid;
    logic [BW-1:0]       entry_byte;
    logic [TW-1:0]       due;
    logic [STATUS_W-1:0] status;
    logic [CW-1:0]       removed;
    logic [CW-1:0]       occ;
    logic                last;
  } rtq_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic [KIND_W-1:0]   kind_i = KIND_ADD;
  logic [BW-1:0]       byte_position_i = '0;
  logic [TW-1:0]       delay_i = '0;
  logic [TW-1:0]       current_time_i = '0;
  logic                busy_o;
  logic                result_stb_o;
  logic                entry_valid_o;
  logic [BW-1:0]       entry_byte_o;
  logic [TW-1:0]       entry_due_o;
  logic [STATUS_W-1:0] status_o;
  logic [CW-1:0]       removed_count_o;
  logic [CW-1:0]       occupancy_o;
  logic                last_o;

  // Shadow copy of the queue contents, front at index 0.
  logic [BW-1:0] shadow_byte [DEPTH];
  logic [TW-1:0] shadow_due [DEPTH];
  int            shadow_fill = 0;

  rtq_result_t   due_results[$];  // results owed by the block, oldest first
  int            fail_count = 0;
  int            stall_cycles = 0;
  bit            gaps_on = 1'b1;

  // Stimulus-side notion of time and of the next segment's byte start.
  logic [TW-1:0] wall_now;
  logic [BW-1:0] next_seg;

  retransmit_timer_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .byte_position_i (byte_position_i),
    .delay_i         (delay_i),
    .current_time_i  (current_time_i),
    .result_stb_o    (result_stb_o),
    .entry_valid_o   (entry_valid_o),
    .entry_byte_o    (entry_byte_o),
    .entry_due_o     (entry_due_o),
    .status_o        (status_o),
    .removed_count_o (removed_count_o),
    .occupancy_o     (occupancy_o),
    .last_o          (last_o)
  );

  initial forever #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Queue one expected result; occupancy is whatever the shadow holds now.
  task automatic owe_result(input logic valid, input logic [BW-1:0] b,
                            input logic [TW-1:0] d, input logic [STATUS_W-1:0] st,
                            input int removed, input logic last);
    rtq_result_t r;
    r.valid      = valid;
    r.entry_byte = valid ? b : '0;
    r.due        = valid ? d : '0;
    r.status     = st;
    r.removed    = CW'(removed);
    r.occ        = CW'(shadow_fill);
    r.last       = last;
    due_results = {due_results, r};
  endtask

  task automatic shift_out_front();
    for (int i = 1; i < shadow_fill; i++) begin
      shadow_byte[i-1] = shadow_byte[i];
      shadow_due[i-1]  = shadow_due[i];
    end
    shadow_fill--;
  endtask

  // Apply one accepted command word to the shadow queue and owe its results.
  task automatic apply_queue_op(input logic [KIND_W-1:0] kind, input logic [BW-1:0] pos,
                                input logic [TW-1:0] dly, input logic [TW-1:0] now);
    logic [TW:0]   sum;
    logic [BW-1:0] b;
    logic [TW-1:0] d;
    int            kept;
    int            n_due;
    case (kind)
      KIND_ADD: begin
        // Due time saturates rather than wrapping.
        sum = {1'b0, now} + {1'b0, dly};
        d   = sum[TW] ? '1 : sum[TW-1:0];
        if (shadow_fill >= DEPTH) begin
          owe_result(1'b0, '0, '0, ST_FULL, 0, 1'b1);
        end else begin
          shadow_byte[shadow_fill] = pos;
          shadow_due[shadow_fill]  = d;
          shadow_fill++;
          owe_result(1'b1, pos, d, ST_OK, 0, 1'b1);
        end
      end
      KIND_ACK: begin
        // Keep entries strictly above the acked byte, in order.
        kept = 0;
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_byte[i] > pos) begin
            shadow_byte[kept] = shadow_byte[i];
            shadow_due[kept]  = shadow_due[i];
            kept++;
          end
        end
        b = BW'(shadow_fill - kept);
        shadow_fill = kept;
        owe_result(1'b0, '0, '0, ST_OK, int'(b), 1'b1);
      end
      KIND_EXPIRE: begin
        // Front entries pop in order, so the due run is a prefix of the queue.
        n_due = 0;
        while (n_due < shadow_fill && shadow_due[n_due] <= now) n_due++;
        if (n_due == 0) begin
          owe_result(1'b0, '0, '0, (shadow_fill == 0) ? ST_EMPTY : ST_OK, 0, 1'b1);
        end
        for (int i = 0; i < n_due; i++) begin
          b = shadow_byte[0];
          d = shadow_due[0];
          shift_out_front();
          owe_result(1'b1, b, d, ST_OK, 0, i == n_due - 1);
        end
      end
      KIND_PEEK: begin
        if (shadow_fill == 0) owe_result(1'b0, '0, '0, ST_EMPTY, 0, 1'b1);
        else owe_result(1'b1, shadow_byte[0], shadow_due[0], ST_OK, 0, 1'b1);
      end
      KIND_POP: begin
        if (shadow_fill == 0) begin
          owe_result(1'b0, '0, '0, ST_EMPTY, 0, 1'b1);
        end else begin
          b = shadow_byte[0];
          d = shadow_due[0];
          shift_out_front();
          owe_result(1'b1, b, d, ST_OK, 1, 1'b1);
        end
      end
      default: owe_result(1'b0, '0, '0, ST_OK, 0, 1'b1);  // unused code, no effect
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Drop start and idle the sender; n sets how long.
  task automatic idle_sender(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Present one command word and hold it until taken (start high, busy low).
  // Called at a rising edge; returns at the edge that took the word.
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [BW-1:0] pos,
                           input logic [TW-1:0] dly, input logic [TW-1:0] now);
    start_i         <= 1'b1;
    kind_i          <= kind;
    byte_position_i <= pos;
    delay_i         <= dly;
    current_time_i  <= now;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    apply_queue_op(kind, pos, dly, now);
    if (gaps_on && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 14));
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Results cannot be stalled: take one on every edge the strobe is high.
  always @(posedge clk_i) begin : result_check
    rtq_result_t want;
    if (rst_ni && result_stb_o) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %0h due %0h status %0d",
                 $time, entry_byte_o, entry_due_o, status_o);
        fail_count++;
      end else begin
        want = due_results[0];
        due_results.delete(0);
        check_field("entry_valid",   want.valid,      entry_valid_o);
        check_field("entry_byte",    want.entry_byte, entry_byte_o);
        check_field("entry_due",     want.due,        entry_due_o);
        check_field("status",        want.status,     status_o);
        check_field("removed_count", want.removed,    removed_count_o);
        check_field("occupancy",     want.occ,        occupancy_o);
        check_field("last",          want.last,       last_o);
      end
    end
  end

  // Watchdog: no word taken and no result for too long means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_stb_o) begin
        stall_cycles = 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Peek, pop, expire and acknowledge on an empty queue.
  task automatic test_empty_queue();
    send_word(KIND_PEEK,   '0, '0, '0);
    send_word(KIND_POP,    '1, '1, '1);
    send_word(KIND_EXPIRE, '0, '0, '1);
    send_word(KIND_ACK,    '1, '0, '0);
  endtask

  // Codes above pop are ignored but still answer once.
  task automatic test_unused_codes();
    for (int k = int'(KIND_POP) + 1; k < (1 << KIND_W); k++)
      send_word(KIND_W'(k), '1, '1, '1);
  endtask

  // Fill to the brim with extreme values, overflow once, then take it apart.
  task automatic test_full_queue_and_drain();
    logic [TW-1:0] t;
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: send_word(KIND_ADD, '0, '0, '0);              // due 0
        1: send_word(KIND_ADD, '1, '1, TW'(1));          // saturates
        2: send_word(KIND_ADD, BW'(100), TW'(5), '1);    // saturates from the top
        default: begin
          t = i[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
          send_word(KIND_ADD, BW'(1000 + 10 * i), TW'(i), t);
        end
      endcase
    end
    send_word(KIND_ADD, BW'(9999), TW'(1), TW'(1));      // dropped, queue full
    send_word(KIND_PEEK, '0, '0, '0);
    send_word(KIND_EXPIRE, '0, '0, '0);                  // pops only the due-0 entry
    send_word(KIND_ACK, BW'(1050), '0, '0);              // removes from the middle
    send_word(KIND_POP, '0, '0, '0);
    send_word(KIND_EXPIRE, '0, '0, '1);                  // everything left is due
  endtask

  // Traffic shaped like a sender: rising byte starts, acks near stored entries,
  // expiries as time advances, occasional full bursts and some raw noise.
  task automatic test_random_traffic(input int n_words);
    int            sent;
    int            pick;
    int            idx;
    bit            was_full;
    logic [KIND_W-1:0] noise_kind;
    logic [TW-1:0] dly;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        dly = ($urandom_range(0, 4) == 0) ? TW'($urandom) : TW'($urandom_range(0, 40));
        send_word(KIND_ADD, next_seg, dly, wall_now);
        next_seg += BW'($urandom_range(1, 1460));
        wall_now += TW'($urandom_range(0, 3));
        sent++;
      end else if (pick < 60) begin
        // Hit a stored byte start exactly or one either side of it.
        if (shadow_fill > 0) begin
          idx = $urandom_range(0, shadow_fill - 1);
          send_word(KIND_ACK, shadow_byte[idx] + BW'($urandom_range(0, 2)) - BW'(1), '0, '0);
        end else begin
          send_word(KIND_ACK, next_seg, '0, '0);
        end
        sent++;
      end else if (pick < 75) begin
        wall_now += TW'($urandom_range(0, 30));
        send_word(KIND_EXPIRE, BW'($urandom), TW'($urandom), wall_now);
        sent++;
      end else if (pick < 82) begin
        send_word(KIND_PEEK, BW'($urandom), TW'($urandom), TW'($urandom));
        sent++;
      end else if (pick < 89) begin
        send_word(KIND_POP, BW'($urandom), TW'($urandom), TW'($urandom));
        sent++;
      end else if (pick < 94) begin
        // Fill past full, then often flush the lot in one expire.
        while (sent < n_words) begin
          was_full = (shadow_fill == DEPTH);
          send_word(KIND_ADD, next_seg, TW'($urandom_range(0, 40)), wall_now);
          next_seg += BW'($urandom_range(1, 1460));
          sent++;
          if (was_full) break;
        end
        if ($urandom_range(0, 1) == 1) begin
          wall_now += TW'(100);
          send_word(KIND_EXPIRE, '0, '0, wall_now);
          sent++;
        end
      end else begin
        noise_kind = KIND_W'($urandom);
        send_word(noise_kind, BW'($urandom), TW'($urandom), TW'($urandom));
        if (noise_kind <= KIND_POP) sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_unused_codes();
    test_full_queue_and_drain();

    // Start time and byte counter anywhere so wraparound and saturation occur.
    wall_now = TW'($urandom);
    next_seg = BW'($urandom);
    test_random_traffic(310);

    // Closing stretch with start held high word after word.
    gaps_on = 1'b0;
    test_random_traffic(90);
    start_i <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* retransmit_timer_queue.f */
+incdir+rtl
rtl/rtq_pkg.sv
rtl/rtq_ram.sv
rtl/rtq_ctrl.sv
rtl/rtq_datapath.sv
rtl/retransmit_timer_queue.sv
rtl/rtq_sva.sv
tb/sv/retransmit_timer_queue_test.sv
